// ===== rtl/cdwe_pkg.sv =====
// Shared types, constants and helpers for the console dump window extractor.
`default_nettype none
package cdwe_pkg;

   localparam int MAX_ROWS = 8;
   localparam int MAX_COLS = 32;

   localparam int ROW_W   = 3;
   localparam int COL_W   = 5;
   localparam int KROWS_W = 4;
   localparam int KCOLS_W = 6;
   localparam int RSP_TDATA_W = 40;

   localparam logic [1:0] HDR_LAST = 2'd3;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DEL   = 8'h7F;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEADER,
      PH_BODY
   } phase_type;

   typedef enum logic [1:0] {
      KIND_CELL,
      KIND_DONE,
      KIND_ERROR
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [ROW_W-1:0]    cell_row;
      logic [COL_W-1:0]    cell_col;
      logic [7:0]          cell_char;
      logic [KROWS_W-1:0]  window_rows;
      logic [KCOLS_W-1:0]  window_cols;
      logic [COL_W-1:0]    cursor_col;
      logic [7:0]          cursor_row;
   } result_type;

   function automatic logic [7:0] clean_char(input logic [7:0] c);
      if (c < CHAR_SPACE || c == CHAR_DEL) begin
         return CHAR_SPACE;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/cdwe_in_reg.sv =====
// Input register stage: holds one accepted request transaction.
`default_nettype none
module cdwe_in_reg (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic       req_tuser,
   input  wire logic [7:0] req_tdata,
   input  wire logic       advance,
   output logic            item_valid,
   output logic            item_frame_start,
   output logic [7:0]      item_data
);
   import cdwe_pkg::*;

   logic       valid_ff, valid_in;
   logic       fs_ff;
   logic [7:0] data_ff;

   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         fs_ff   <= req_tuser;
         data_ff <= req_tdata;
      end
   end

   assign item_valid       = valid_ff;
   assign item_frame_start = fs_ff;
   assign item_data        = data_ff;

endmodule
`default_nettype wire

// ===== rtl/cdwe_parser.sv =====
// Dump parser: header capture, window setup or header error, and per-byte cell/complete decode.
`default_nettype none
module cdwe_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                item_valid,
   input  wire logic                item_frame_start,
   input  wire logic [7:0]          item_data,
   input  wire logic                step,
   output logic                     res_valid,
   output cdwe_pkg::result_type     result
);
   import cdwe_pkg::*;

   phase_type            phase_ff, phase_in, ph;
   logic [1:0]           hidx_ff, hidx_in, hidx;
   logic [7:0]           grid_rows_ff, grid_rows_in;
   logic [7:0]           grid_cols_ff, grid_cols_in;
   logic [7:0]           raw_col_ff, raw_col_in;
   logic [7:0]           raw_row_ff, raw_row_in;
   logic [KROWS_W-1:0]   kept_rows_ff, kept_rows_in;
   logic [KCOLS_W-1:0]   kept_cols_ff, kept_cols_in;
   logic [7:0]           wstart_ff, wstart_in;
   logic [7:0]           row_cnt_ff, row_cnt_in;
   logic [8:0]           bir_ff, bir_in;

   logic                 has;
   logic [KROWS_W-1:0]   kr;
   logic [KCOLS_W-1:0]   kc;
   logic [8:0]           start;
   logic [7:0]           col;
   logic                 last_in_row, last_item, in_win;
   logic [8:0]           row_rel;

   assign kr = (grid_rows_ff < 8'(MAX_ROWS)) ? grid_rows_ff[KROWS_W-1:0]
                                              : KROWS_W'(MAX_ROWS);
   assign kc = (grid_cols_ff < 8'(MAX_COLS)) ? grid_cols_ff[KCOLS_W-1:0]
                                              : KCOLS_W'(MAX_COLS);

   always_comb begin
      if ({1'b0, item_data} >= 9'(kr)) begin
         start = {1'b0, item_data} + 9'd1 - 9'(kr);
      end else begin
         start = 9'd0;
      end
      if (start + 9'(kr) > {1'b0, grid_rows_ff}) begin
         start = {1'b0, grid_rows_ff} - 9'(kr);
      end
   end

   assign col         = bir_ff[8:1];
   assign last_in_row = (10'(bir_ff) + 10'd1) >= {1'b0, grid_cols_ff, 1'b0};
   assign last_item   = last_in_row && ((9'(row_cnt_ff) + 9'd1) >= {1'b0, grid_rows_ff});
   assign row_rel     = {1'b0, row_cnt_ff} - {1'b0, wstart_ff};
   assign in_win      = !bir_ff[0] && (row_cnt_ff >= wstart_ff) &&
                        ({1'b0, row_cnt_ff} < ({1'b0, wstart_ff} + 9'(kept_rows_ff))) &&
                        ({1'b0, col} < 9'(kept_cols_ff));

   always_comb begin
      phase_in     = phase_ff;
      hidx_in      = hidx_ff;
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      raw_col_in   = raw_col_ff;
      raw_row_in   = raw_row_ff;
      kept_rows_in = kept_rows_ff;
      kept_cols_in = kept_cols_ff;
      wstart_in    = wstart_ff;
      row_cnt_in   = row_cnt_ff;
      bir_in       = bir_ff;
      has          = 1'b0;
      result       = '0;

      ph   = item_frame_start ? PH_HEADER : phase_ff;
      hidx = item_frame_start ? 2'd0 : hidx_ff;
      phase_in = ph;
      hidx_in  = hidx;

      case (ph)
         PH_HEADER: begin
            case (hidx)
               2'd0:    grid_rows_in = item_data;
               2'd1:    grid_cols_in = item_data;
               2'd2:    raw_col_in   = item_data;
               default: raw_row_in   = item_data;
            endcase
            if (hidx != HDR_LAST) begin
               hidx_in = hidx + 2'd1;
            end else begin
               hidx_in = 2'd0;
               if (grid_rows_ff == 8'd0 || grid_cols_ff == 8'd0) begin
                  phase_in    = PH_IDLE;
                  has         = 1'b1;
                  result.kind = KIND_ERROR;
               end else begin
                  kept_rows_in = kr;
                  kept_cols_in = kc;
                  wstart_in    = start[7:0];
                  row_cnt_in   = 8'd0;
                  bir_in       = 9'd0;
                  phase_in     = PH_BODY;
               end
            end
         end
         PH_BODY: begin
            if (in_win) begin
               has              = 1'b1;
               result.kind      = KIND_CELL;
               result.cell_row  = row_rel[ROW_W-1:0];
               result.cell_col  = col[COL_W-1:0];
               result.cell_char = clean_char(item_data);
            end
            if (last_item) begin
               has                = 1'b1;
               result             = '0;
               result.kind        = KIND_DONE;
               result.window_rows = kept_rows_ff;
               result.window_cols = kept_cols_ff;
               result.cursor_col  = ({2'b0, kept_cols_ff} > raw_col_ff) ?
                                    raw_col_ff[COL_W-1:0] :
                                    COL_W'(kept_cols_ff - KCOLS_W'(1));
               result.cursor_row  = (raw_row_ff >= wstart_ff) ? raw_row_ff - wstart_ff
                                                              : 8'd0;
               phase_in   = PH_IDLE;
               row_cnt_in = 8'd0;
               bir_in     = 9'd0;
            end else if (last_in_row) begin
               bir_in     = 9'd0;
               row_cnt_in = row_cnt_ff + 8'd1;
            end else begin
               bir_in = bir_ff + 9'd1;
            end
         end
         default: begin
         end
      endcase
   end

   assign res_valid = item_valid && has;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         hidx_ff      <= 2'd0;
         grid_rows_ff <= 8'd0;
         grid_cols_ff <= 8'd0;
         raw_col_ff   <= 8'd0;
         raw_row_ff   <= 8'd0;
         kept_rows_ff <= '0;
         kept_cols_ff <= '0;
         wstart_ff    <= 8'd0;
         row_cnt_ff   <= 8'd0;
         bir_ff       <= 9'd0;
      end else if (step) begin
         phase_ff     <= phase_in;
         hidx_ff      <= hidx_in;
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
         raw_col_ff   <= raw_col_in;
         raw_row_ff   <= raw_row_in;
         kept_rows_ff <= kept_rows_in;
         kept_cols_ff <= kept_cols_in;
         wstart_ff    <= wstart_in;
         row_cnt_ff   <= row_cnt_in;
         bir_ff       <= bir_in;
      end
   end

   a_body_nonempty: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> kept_rows_ff != '0 && kept_cols_ff != '0)
      else $error("body phase with empty window");

   a_window_fits: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |->
         ({1'b0, wstart_ff} + 9'(kept_rows_ff)) <= {1'b0, grid_rows_ff})
      else $error("window extends past grid");

   a_error_idles: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && result.kind == KIND_ERROR |=> phase_ff == PH_IDLE)
      else $error("error transaction did not return to idle");

   a_cell_in_cols: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && result.kind == KIND_CELL |->
         {1'b0, result.cell_col} < kept_cols_ff)
      else $error("cell write outside kept columns");

endmodule
`default_nettype wire

// ===== rtl/cdwe_out_reg.sv =====
// Result register: holds one response transaction until taken.
`default_nettype none
module cdwe_out_reg (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire cdwe_pkg::result_type data,
   output logic                     out_free,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output cdwe_pkg::result_type     rsp_data
);
   import cdwe_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign out_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_data   = data_ff;

endmodule
`default_nettype wire

// ===== rtl/console_dump_window_extractor_core.sv =====
// Top level of the console dump window extractor.
//
//  channel | dir | tdata                       | tuser
//  req_    | in  | data_byte                   | frame_start
//  rsp_    | out | row,col,char,wrows,wcols,.. | kind
//
// One byte per cycle sustained unless a result waits on a stalled response;
// each byte waits in the input register, then its result is loaded into the result register.
// Reset clears the parser state to idle and empties both registers.
// A stalled response only holds req_tready low when the waiting byte
// produces a result; bytes without a result keep flowing.
`default_nettype none
module console_dump_window_extractor_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] frame_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [cdwe_pkg::RSP_TDATA_W-1:0] rsp_tdata,
                                         // [2:0] cell_row, [7:3] cell_col,
                                         // [15:8] cell_char, [19:16] window_rows,
                                         // [25:20] window_cols, [30:26] cursor_col,
                                         // [38:31] cursor_row, [39] zero
   output logic [1:0]       rsp_tuser    // [1:0] kind
);
   import cdwe_pkg::*;

   logic       item_valid, item_fs;
   logic [7:0] item_data;
   logic       advance, res_valid, out_free;
   result_type result, rsp_data;

   assign advance = item_valid && (!res_valid || out_free);

   cdwe_in_reg u_in (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tuser        (req_tuser),
      .req_tdata        (req_tdata),
      .advance          (advance),
      .item_valid       (item_valid),
      .item_frame_start (item_fs),
      .item_data        (item_data)
   );

   cdwe_parser u_parser (
      .clock            (clock),
      .reset            (reset),
      .item_valid       (item_valid),
      .item_frame_start (item_fs),
      .item_data        (item_data),
      .step             (advance),
      .res_valid        (res_valid),
      .result           (result)
   );

   cdwe_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && res_valid),
      .data       (result),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tuser = rsp_data.kind;
   assign rsp_tdata = {1'b0, rsp_data.cursor_row, rsp_data.cursor_col,
                       rsp_data.window_cols, rsp_data.window_rows,
                       rsp_data.cell_char, rsp_data.cell_col, rsp_data.cell_row};

endmodule
`default_nettype wire
